>>> src/indexed_priority_heap_core_macros.svh
// Assertion macros used by the heap controller.
// Depends on nothing; included by iph_control.
`ifndef INDEXED_PRIORITY_HEAP_CORE_MACROS_SVH
`define INDEXED_PRIORITY_HEAP_CORE_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define IPH_ASSERT_IMP(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("heap check failed");

// Next-cycle implication checked outside reset.
`define IPH_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("heap check failed");

`endif

>>> src/iph_pkg.sv
// Package of the indexed priority heap: types, codes and sizes.
// Depends on nothing; used by every module of the block.
package iph_pkg;

  localparam int CAPACITY = 256;
  localparam int PRIORITY_BITS = 32;
  localparam int ADDR_BITS = $clog2(CAPACITY);
  localparam int COUNT_BITS = $clog2(CAPACITY + 1);

  localparam logic [2:0] KIND_MOVED = 3'd0;
  localparam logic [2:0] KIND_REMOVED = 3'd1;
  localparam logic [2:0] KIND_INSERTED = 3'd2;
  localparam logic [2:0] KIND_FULL = 3'd3;
  localparam logic [2:0] KIND_BAD_POS = 3'd4;

  typedef struct packed {
    logic [15:0] handle;
    logic [PRIORITY_BITS-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic mode;
    logic [15:0] handle;
    logic [31:0] priority_req;
    logic [7:0] position;
  } in_word_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [15:0] out_handle;
    logic [31:0] out_priority;
    logic [7:0] new_position;
    logic last;
  } out_word_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_CHECK, ST_RM_CAP, ST_RM_OUT, ST_FILL,
    ST_UP_RD, ST_UP_CAP, ST_UP_DEC,
    ST_DN_RD, ST_DN_CAP_A, ST_DN_CAP_B, ST_DN_DEC,
    ST_SW_PEND, ST_SW_A, ST_SW_B, ST_END, ST_ERR_OUT
  } state_t;

  typedef enum logic [2:0] {
    RD_NONE, RD_CUR, RD_PAR, RD_LEFT, RD_RIGHT, RD_LAST
  } rd_sel_t;

  // Controller to datapath.
  typedef struct packed {
    logic take_in;
    logic inc_count;
    logic dec_count;
    rd_sel_t rd;
    logic cap_cur;
    logic cap_a;
    logic cap_b;
    logic wr_cur_a;
    logic wr_other_cur;
    logic wr_fill;
    logic wr_new;
    logic go_other;
    logic set_dir_up;
    logic load_out;
    logic [2:0] out_kind;
    logic [1:0] out_src;
    logic out_last;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic mode;
    logic full;
    logic bad_pos;
    logic pos_is_last;
    logic at_root;
    logic has_left;
    logic has_right;
    logic up_swap;
    logic down_swap;
    logic dir_up;
  } status_t;

  localparam logic [1:0] SRC_CUR = 2'd0;
  localparam logic [1:0] SRC_OTHER = 2'd1;
  localparam logic [1:0] SRC_INPUT = 2'd2;
  localparam logic [1:0] SRC_BAD = 2'd3;

endpackage

>>> src/iph_datapath.sv
// Datapath of the heap: entry store, slot registers, compares and result word.
// Depends on iph_pkg.
module iph_datapath
  import iph_pkg::*;
(
  input logic clk,
  input logic rst,
  input in_word_t in_word,
  input cmd_t cmd,
  output status_t status,
  output out_word_t out_word
);

  entry_t store [CAPACITY];
  entry_t rd_data;
  logic [COUNT_BITS-1:0] count;
  in_word_t req;
  logic [ADDR_BITS-1:0] cur;
  logic [ADDR_BITS-1:0] other;
  entry_t cur_e;
  entry_t a_e;
  entry_t b_e;
  logic dir_up;
  logic [ADDR_BITS:0] left_w;
  logic [ADDR_BITS:0] right_w;
  logic [ADDR_BITS-1:0] par;
  logic [ADDR_BITS-1:0] rd_addr;
  logic [ADDR_BITS-1:0] wr_addr;
  entry_t wr_data;
  logic wr_en;
  logic right_win;
  logic [ADDR_BITS-1:0] child;
  entry_t child_e;
  entry_t new_e;

  assign left_w = {cur, 1'b1};
  assign right_w = {cur, 1'b0} + (ADDR_BITS + 1)'(2);
  assign par = (cur - ADDR_BITS'(1)) >> 1;
  assign new_e.handle = req.handle;
  assign new_e.prio = PRIORITY_BITS'(req.priority_req);
  assign right_win = status.has_right && (b_e.prio > a_e.prio);
  assign child = right_win ? right_w[ADDR_BITS-1:0] : left_w[ADDR_BITS-1:0];
  assign child_e = right_win ? b_e : a_e;

  always_comb begin
    rd_addr = cur;
    unique case (cmd.rd)
      RD_PAR: rd_addr = par;
      RD_LEFT: rd_addr = left_w[ADDR_BITS-1:0];
      RD_RIGHT: rd_addr = right_w[ADDR_BITS-1:0];
      RD_LAST: rd_addr = count[ADDR_BITS-1:0];
      default: rd_addr = cur;
    endcase
  end

  always_comb begin
    wr_en = 1'b1;
    wr_addr = cur;
    wr_data = cur_e;
    if (cmd.wr_new) begin
      wr_addr = count[ADDR_BITS-1:0];
      wr_data = new_e;
    end else if (cmd.wr_cur_a) begin
      wr_addr = cur;
      wr_data = dir_up ? a_e : child_e;
    end else if (cmd.wr_other_cur) begin
      wr_addr = other;
      wr_data = cur_e;
    end else if (cmd.wr_fill) begin
      wr_addr = cur;
      wr_data = rd_data;
    end else begin
      wr_en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= wr_data;
    end
    if (cmd.rd != RD_NONE) begin
      rd_data <= store[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      dir_up <= 1'b0;
    end else begin
      if (cmd.inc_count) begin
        count <= count + COUNT_BITS'(1);
      end else if (cmd.dec_count) begin
        count <= count - COUNT_BITS'(1);
      end
      if (cmd.set_dir_up) begin
        dir_up <= 1'b1;
      end else if (cmd.take_in) begin
        dir_up <= ~in_word.mode;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      req <= in_word;
      cur <= in_word.mode ? ADDR_BITS'(in_word.position) : count[ADDR_BITS-1:0];
    end
    if (cmd.wr_new) begin
      cur_e <= new_e;
    end
    if (cmd.cap_cur) begin
      cur_e <= rd_data;
    end
    if (cmd.cap_a) begin
      a_e <= rd_data;
    end
    if (cmd.cap_b) begin
      b_e <= rd_data;
    end
    if (cmd.wr_fill) begin
      cur_e <= rd_data;
    end
    if (cmd.wr_cur_a) begin
      other <= dir_up ? par : child;
    end
    if (cmd.go_other) begin
      cur <= other;
    end
    if (cmd.load_out) begin
      out_word.kind <= cmd.out_kind;
      out_word.last <= cmd.out_last;
      unique case (cmd.out_src)
        SRC_OTHER: begin
          out_word.out_handle <= dir_up ? a_e.handle : child_e.handle;
          out_word.out_priority <= 32'(dir_up ? a_e.prio : child_e.prio);
          out_word.new_position <= 8'(cur);
        end
        SRC_INPUT: begin
          out_word.out_handle <= req.handle;
          out_word.out_priority <= 32'(PRIORITY_BITS'(req.priority_req));
          out_word.new_position <= '0;
        end
        SRC_BAD: begin
          out_word.out_handle <= '0;
          out_word.out_priority <= '0;
          out_word.new_position <= req.position;
        end
        default: begin
          out_word.out_handle <= cur_e.handle;
          out_word.out_priority <= 32'(cur_e.prio);
          out_word.new_position <= 8'(cur);
        end
      endcase
    end
  end

  assign status.mode = req.mode;
  assign status.full = (count == COUNT_BITS'(CAPACITY));
  assign status.bad_pos = (COUNT_BITS'(req.position) >= count);
  assign status.pos_is_last = (COUNT_BITS'(cur) == count);
  assign status.at_root = (cur == '0);
  assign status.has_left = ((COUNT_BITS+1)'(left_w) < (COUNT_BITS+1)'(count));
  assign status.has_right = ((COUNT_BITS+1)'(right_w) < (COUNT_BITS+1)'(count));
  assign status.up_swap = (a_e.prio < cur_e.prio);
  assign status.down_swap = (child_e.prio > cur_e.prio);
  assign status.dir_up = dir_up;

endmodule

>>> src/iph_control.sv
// Controller of the heap: sequences inserts, deletes and sifts, drives the
// result handshake. Depends on iph_pkg and the macros header.
`include "indexed_priority_heap_core_macros.svh"
module iph_control
  import iph_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic in_valid,
  output logic in_stall,
  input logic out_stall,
  output logic out_valid,
  input status_t status,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;
  logic pend;
  logic pend_next;
  logic out_valid_next;
  logic out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      pend <= pend_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    pend_next = pend;
    cmd = '0;
    cmd.rd = RD_NONE;
    out_valid_next = out_valid && out_stall;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.take_in = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!status.mode) begin
          if (status.full) begin
            state_next = ST_ERR_OUT;
          end else begin
            cmd.wr_new = 1'b1;
            cmd.inc_count = 1'b1;
            pend_next = 1'b0;
            state_next = ST_UP_RD;
          end
        end else if (status.bad_pos) begin
          state_next = ST_ERR_OUT;
        end else begin
          cmd.rd = RD_CUR;
          cmd.dec_count = 1'b1;
          state_next = ST_RM_CAP;
        end
      end
      ST_RM_CAP: begin
        cmd.cap_cur = 1'b1;
        cmd.rd = RD_LAST;
        state_next = ST_RM_OUT;
      end
      ST_RM_OUT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          cmd.out_kind = KIND_REMOVED;
          cmd.out_src = SRC_CUR;
          cmd.out_last = status.pos_is_last;
          out_valid_next = 1'b1;
          state_next = status.pos_is_last ? ST_IDLE : ST_FILL;
        end
      end
      ST_FILL: begin
        cmd.wr_fill = 1'b1;
        pend_next = 1'b1;
        state_next = ST_UP_RD;
      end
      ST_UP_RD: begin
        if (status.at_root) begin
          state_next = status.dir_up ? ST_END : ST_DN_RD;
        end else begin
          cmd.rd = RD_PAR;
          state_next = ST_UP_CAP;
        end
      end
      ST_UP_CAP: begin
        cmd.cap_a = 1'b1;
        state_next = ST_UP_DEC;
      end
      ST_UP_DEC: begin
        if (status.up_swap) begin
          cmd.set_dir_up = 1'b1;
          state_next = ST_SW_PEND;
        end else begin
          state_next = status.dir_up ? ST_END : ST_DN_RD;
        end
      end
      ST_DN_RD: begin
        if (status.has_left) begin
          cmd.rd = RD_LEFT;
          state_next = ST_DN_CAP_A;
        end else begin
          state_next = ST_END;
        end
      end
      ST_DN_CAP_A: begin
        cmd.cap_a = 1'b1;
        cmd.rd = RD_RIGHT;
        state_next = ST_DN_CAP_B;
      end
      ST_DN_CAP_B: begin
        cmd.cap_b = 1'b1;
        state_next = ST_DN_DEC;
      end
      ST_DN_DEC: begin
        state_next = status.down_swap ? ST_SW_PEND : ST_END;
      end
      ST_SW_PEND: begin
        if (!pend) begin
          state_next = ST_SW_A;
        end else if (out_free) begin
          cmd.load_out = 1'b1;
          cmd.out_kind = KIND_MOVED;
          cmd.out_src = SRC_CUR;
          out_valid_next = 1'b1;
          state_next = ST_SW_A;
        end
      end
      ST_SW_A: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          cmd.out_kind = KIND_MOVED;
          cmd.out_src = SRC_OTHER;
          out_valid_next = 1'b1;
          cmd.wr_cur_a = 1'b1;
          state_next = ST_SW_B;
        end
      end
      ST_SW_B: begin
        cmd.wr_other_cur = 1'b1;
        cmd.go_other = 1'b1;
        pend_next = 1'b1;
        state_next = status.dir_up ? ST_UP_RD : ST_DN_RD;
      end
      ST_END: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          cmd.out_src = SRC_CUR;
          out_valid_next = 1'b1;
          if (pend) begin
            cmd.out_kind = KIND_MOVED;
            cmd.out_last = status.mode;
            pend_next = 1'b0;
            state_next = status.mode ? ST_IDLE : ST_END;
          end else begin
            cmd.out_kind = KIND_INSERTED;
            cmd.out_last = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
      ST_ERR_OUT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          cmd.out_last = 1'b1;
          cmd.out_kind = status.mode ? KIND_BAD_POS : KIND_FULL;
          cmd.out_src = status.mode ? SRC_BAD : SRC_INPUT;
          out_valid_next = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `IPH_ASSERT_IMP(a_stall_busy, clk, rst, state != ST_IDLE, in_stall)
  `IPH_ASSERT_NEXT(a_take_leaves_idle, clk, rst, state == ST_IDLE && in_valid, state == ST_CHECK)
  `IPH_ASSERT_IMP(a_no_overwrite, clk, rst, out_valid && out_stall, !cmd.load_out)

endmodule

>>> src/indexed_priority_heap_core.sv
// Indexed binary max-heap of (priority, handle) entries, 256 slots.
// Each item is an insert or a delete and yields a stream of result words that
// report every slot change, or a single error word for a full heap or a bad
// position; the last word of an item carries last = 1. One item is in work at
// a time, and the entry memory is read through a register. An insert lets the
// new entry rise level by level; a delete that frees a slot other than the last
// moves the last entry into it and lets it rise or sink. A stalled result word
// holds the sequence until it is taken.
// Depends on iph_pkg, iph_control and iph_datapath.
module indexed_priority_heap_core
  import iph_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic in_valid,
  output logic in_stall,
  input in_word_t in_data,
  output logic out_valid,
  input logic out_stall,
  output out_word_t out_data
);

  cmd_t cmd;
  status_t status;

  iph_control u_control (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_stall(out_stall), .out_valid(out_valid), .status(status), .cmd(cmd)
  );

  iph_datapath u_datapath (
    .clk(clk), .rst(rst), .in_word(in_data), .cmd(cmd), .status(status),
    .out_word(out_data)
  );

endmodule
